>>> rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and helpers for the sorted priority queue
// Holds the store depth, derived widths, command and status codes, the
// state encoding and the circular pointer arithmetic.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Store depth and derived widths
  localparam int DEPTH   = 16;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int FIELD_W = 5;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [ADDR_W:0]  DEPTH_EXT = (ADDR_W + 1)'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Request commands
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_HEAD,
    ST_SRCH,
    ST_REM,
    ST_RESP
  } state_t;

  // Advance a circular pointer by one
  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    return (p == LAST_ADDR) ? '0 : p + ADDR_W'(1);
  endfunction

  // Step a circular pointer back by one
  function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
    return (p == '0) ? LAST_ADDR : p - ADDR_W'(1);
  endfunction

  // Add an offset below DEPTH to a circular pointer
  function automatic logic [ADDR_W-1:0] ptr_add(input logic [ADDR_W-1:0] p,
                                                input logic [ADDR_W-1:0] n);
    logic [ADDR_W:0] s;
    logic [ADDR_W:0] w;
    s = {1'b0, p} + {1'b0, n};
    w = (s >= DEPTH_EXT) ? s - DEPTH_EXT : s;
    return w[ADDR_W-1:0];
  endfunction

  // Fit a count into a result field, dropping high bits
  function automatic logic [FIELD_W-1:0] fit_field(input logic [CNT_W-1:0] x);
    logic [CNT_W+FIELD_W-1:0] ext;
    ext = {{FIELD_W{1'b0}}, x};
    return ext[FIELD_W-1:0];
  endfunction

endpackage

>>> rtl/core/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: max-first priority queue in a sorted store
// Usage: a request on in_cmd/in_value (insert, remove head, search) is taken
// with in_valid/in_ready; exactly one result per request leaves on out_*
// with out_valid/out_ready. Entries sit in one synchronous RAM as a circular
// list, largest at the head pointer, with one read and one write per cycle.
// Steps from acceptance to result (n = entries held before the request):
//   remove: one RAM read of the head, then the result.
//   search: n RAM reads, one entry compared per read, then the result.
//   insert: read-compare-write walk from the tail, shifting up to n entries
//           toward the tail, then the result.
//   insert into empty, full insert, empty remove/search, unused code: no RAM walk.
// One request is in work at a time; in_ready is high only while idle, so
// no new request is taken before the current one reaches its result.
// Reset empties the queue at once (no clearing pass); RAM contents are not
// cleared and are only read inside the held range.
// When the receiver stalls, the result holds in the output register; the
// next request may still be taken and worked, and its finished result then
// waits until the output register frees before the block goes idle again.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_removed_value,
  output logic [4:0]          out_position,
  output logic [4:0]          out_match_count,
  output logic [4:0]          out_occupancy
);

  // Control state
  spq_pkg::state_t                   state_r, state_nxt;
  logic [spq_pkg::ADDR_W-1:0]        head_r, head_nxt;
  logic [spq_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [spq_pkg::ADDR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [spq_pkg::CNT_W-1:0]         left_r, left_nxt;
  logic [spq_pkg::CNT_W-1:0]         idx_r, idx_nxt;
  logic [spq_pkg::CNT_W-1:0]         hit_cnt_r, hit_cnt_nxt;
  logic [spq_pkg::CNT_W-1:0]         hit_pos_r, hit_pos_nxt;
  spq_pkg::status_t                  res_status_r, res_status_nxt;
  logic signed [31:0]                val_r, val_nxt;

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  logic [1:0]                        out_status_r, out_status_nxt;
  logic signed [31:0]                out_removed_r, out_removed_nxt;
  logic [4:0]                        out_pos_r, out_pos_nxt;
  logic [4:0]                        out_cnt_r, out_cnt_nxt;
  logic [4:0]                        out_occ_r, out_occ_nxt;

  // RAM ports
  logic signed [31:0]                entry_mem_r [spq_pkg::DEPTH];
  logic signed [31:0]                rd_data_r;
  logic                              rd_en;
  logic [spq_pkg::ADDR_W-1:0]        rd_addr;
  logic                              wr_en;
  logic [spq_pkg::ADDR_W-1:0]        wr_addr;
  logic signed [31:0]                wr_data;

  logic                              slot_free;
  logic                              hit;
  logic [spq_pkg::CNT_W-1:0]         count_m1;

  assign in_ready          = (state_r == spq_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_position      = out_pos_r;
  assign out_match_count   = out_cnt_r;
  assign out_occupancy     = out_occ_r;

  assign slot_free = !out_valid_r || out_ready;
  assign hit       = (rd_data_r == val_r);
  assign count_m1  = count_r - spq_pkg::CNT_W'(1);

  // Entry RAM: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= entry_mem_r[rd_addr];
    end
  end

  // Sequencer: next state, RAM control and result
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    left_nxt       = left_r;
    idx_nxt        = idx_r;
    hit_cnt_nxt    = hit_cnt_r;
    hit_pos_nxt    = hit_pos_r;
    res_status_nxt = res_status_r;
    val_nxt        = val_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    wr_en          = 1'b0;
    wr_addr        = head_r;
    wr_data        = val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_removed_nxt = out_removed_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;
    out_occ_nxt    = out_occ_r;

    case (state_r)
      spq_pkg::ST_IDLE: begin
        if (in_valid) begin
          val_nxt        = in_value;
          hit_cnt_nxt    = '0;
          hit_pos_nxt    = '0;
          res_status_nxt = spq_pkg::STAT_OK;
          state_nxt      = spq_pkg::ST_RESP;
          case (in_cmd)
            spq_pkg::CMD_INSERT: begin
              if (count_r == spq_pkg::DEPTH_CNT) begin
                res_status_nxt = spq_pkg::STAT_FULL;
              end else if (count_r == '0) begin
                // empty store: place at head directly
                wr_en     = 1'b1;
                wr_addr   = head_r;
                wr_data   = in_value;
                count_nxt = count_r + spq_pkg::CNT_W'(1);
              end else begin
                // start the walk at the tail entry
                rd_en      = 1'b1;
                rd_addr    = spq_pkg::ptr_add(head_r, count_m1[spq_pkg::ADDR_W-1:0]);
                rd_ptr_nxt = rd_addr;
                left_nxt   = count_r;
                count_nxt  = count_r + spq_pkg::CNT_W'(1);
                state_nxt  = spq_pkg::ST_INS;
              end
            end
            spq_pkg::CMD_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = spq_pkg::STAT_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                head_nxt  = spq_pkg::ptr_inc(head_r);
                count_nxt = count_m1;
                state_nxt = spq_pkg::ST_REM;
              end
            end
            spq_pkg::CMD_SEARCH: begin
              if (count_r == '0) begin
                res_status_nxt = spq_pkg::STAT_NOT_FOUND;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head_r;
                rd_ptr_nxt = head_r;
                left_nxt   = count_r;
                idx_nxt    = spq_pkg::CNT_W'(1);
                state_nxt  = spq_pkg::ST_SRCH;
              end
            end
            default: begin
              res_status_nxt = spq_pkg::STAT_OK;
            end
          endcase
        end
      end

      spq_pkg::ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = spq_pkg::ptr_inc(rd_ptr_r);
        if (val_r >= rd_data_r) begin
          // shift this entry one place toward the tail
          wr_data = rd_data_r;
          if (left_r == spq_pkg::CNT_W'(1)) begin
            state_nxt = spq_pkg::ST_INS_HEAD;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = spq_pkg::ptr_dec(rd_ptr_r);
            rd_ptr_nxt = rd_addr;
            left_nxt   = left_r - spq_pkg::CNT_W'(1);
          end
        end else begin
          // drop the new value in behind the larger entry
          wr_data   = val_r;
          state_nxt = spq_pkg::ST_RESP;
        end
      end

      spq_pkg::ST_INS_HEAD: begin
        wr_en     = 1'b1;
        wr_addr   = rd_ptr_r;
        wr_data   = val_r;
        state_nxt = spq_pkg::ST_RESP;
      end

      spq_pkg::ST_SRCH: begin
        if (hit) begin
          hit_cnt_nxt = hit_cnt_r + spq_pkg::CNT_W'(1);
          if (hit_cnt_r == '0) begin
            hit_pos_nxt = idx_r;
          end
        end
        if (left_r == spq_pkg::CNT_W'(1)) begin
          res_status_nxt = (hit || hit_cnt_r != '0) ? spq_pkg::STAT_OK
                                                     : spq_pkg::STAT_NOT_FOUND;
          state_nxt      = spq_pkg::ST_RESP;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = spq_pkg::ptr_inc(rd_ptr_r);
          rd_ptr_nxt = rd_addr;
          left_nxt   = left_r - spq_pkg::CNT_W'(1);
          idx_nxt    = idx_r + spq_pkg::CNT_W'(1);
        end
      end

      spq_pkg::ST_REM: begin
        // hold until the output register is free
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = spq_pkg::STAT_OK;
          out_removed_nxt = rd_data_r;
          out_pos_nxt     = '0;
          out_cnt_nxt     = '0;
          out_occ_nxt     = spq_pkg::fit_field(count_r);
          state_nxt       = spq_pkg::ST_IDLE;
        end
      end

      spq_pkg::ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_removed_nxt = '0;
          out_pos_nxt     = spq_pkg::fit_field(hit_pos_r);
          out_cnt_nxt     = spq_pkg::fit_field(hit_cnt_r);
          out_occ_nxt     = spq_pkg::fit_field(count_r);
          state_nxt       = spq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r      <= rd_ptr_nxt;
    left_r        <= left_nxt;
    idx_r         <= idx_nxt;
    hit_cnt_r     <= hit_cnt_nxt;
    hit_pos_r     <= hit_pos_nxt;
    res_status_r  <= res_status_nxt;
    val_r         <= val_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_pos_r     <= out_pos_nxt;
    out_cnt_r     <= out_cnt_nxt;
    out_occ_r     <= out_occ_nxt;
  end

endmodule

>>> rtl/core/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the result channel for stall behavior and for field combinations
// that each status code allows.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_removed_value,
  input logic [4:0]         out_position,
  input logic [4:0]         out_match_count,
  input logic [4:0]         out_occupancy
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_removed_value) && $stable(out_occupancy))
    else $error("stalled result changed");

  // Empty status only on an empty queue with nothing removed
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::STAT_EMPTY |->
      out_occupancy == '0 && out_removed_value == '0)
    else $error("empty status with entries held");

  // Full status only with the store at capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::STAT_FULL |->
      out_occupancy == spq_pkg::fit_field(spq_pkg::DEPTH_CNT))
    else $error("full status below capacity");

  // A miss reports no position and no matches
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::STAT_NOT_FOUND |->
      out_position == '0 && out_match_count == '0 && out_removed_value == '0)
    else $error("not-found result carries match data");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
